// ===== hdl/hbs_pkg.sv =====
// Shared types and constants of the heightmap sampler and brush.
package hbs_pkg;

	localparam int GRID_SIDE_DEF = 128;

	// Shared multiplier operand and product widths
	localparam int MUL_W  = 20;
	localparam int PROD_W = 2 * MUL_W;

	// Grid coordinate fraction position inside the scaled product
	localparam int FRAC_BITS = 22;

	localparam logic [9:0]  HALF_SIZE_RST    = 10'd256;
	localparam logic [15:0] GRID_STEP_RST    = 16'd1032;
	localparam logic [15:0] STEP_RECIP_RST   = 16'd16257;
	localparam logic [2:0]  HEIGHT_SHIFT_RST = 3'd2;

	typedef enum logic [1:0] {
		REQ_WRITE,
		REQ_READ,
		REQ_SAMPLE,
		REQ_BRUSH
	} req_t;

	typedef enum logic [1:0] {
		CFG_HALF_SIZE,
		CFG_GRID_STEP,
		CFG_STEP_RECIP,
		CFG_HEIGHT_SHIFT
	} cfg_idx_t;

	typedef struct packed {
		logic [9:0]  half_size;
		logic [15:0] grid_step;
		logic [15:0] step_recip;
		logic [2:0]  height_shift;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_WR,
		ST_RD_A,
		ST_RD_D,
		ST_SX,
		ST_SZ,
		ST_SLZ,
		ST_SR0,
		ST_SR1,
		ST_SR2,
		ST_SR3,
		ST_SM0,
		ST_SM1,
		ST_SM2,
		ST_SM3,
		ST_SFIN,
		ST_B_INIT,
		ST_B_R2,
		ST_B_ROW,
		ST_B_DZ,
		ST_B_CA,
		ST_B_CB
	} state_t;

endpackage

// ===== hdl/hbs_ram.sv =====
// Height store: one write port, one read port with registered read data.
module hbs_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/hbs_mul.sv =====
// Shared signed multiplier with a registered product.
module hbs_mul (
	input  logic                                clk,
	input  logic signed [hbs_pkg::MUL_W-1:0]  a,
	input  logic signed [hbs_pkg::MUL_W-1:0]  b,
	output logic signed [hbs_pkg::PROD_W-1:0] p
);
	import hbs_pkg::*;

	logic signed [PROD_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ===== hdl/hbs_ctrl.sv =====
// Request sequencer and datapath registers around the shared multiplier.
module hbs_ctrl #(
	parameter int GRID_SIDE = hbs_pkg::GRID_SIDE_DEF,
	parameter int AW        = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hbs_pkg::cfg_t                       cfg,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          req_type,
	input  logic [13:0]                         cell_index,
	input  logic [7:0]                          cell_height,
	input  logic signed [15:0]                  world_x,
	input  logic signed [15:0]                  world_z,
	input  logic [15:0]                         brush_radius,
	input  logic                                raise_not_lower,
	output logic signed [hbs_pkg::MUL_W-1:0]  mul_a,
	output logic signed [hbs_pkg::MUL_W-1:0]  mul_b,
	input  logic signed [hbs_pkg::PROD_W-1:0] mul_p,
	output logic                                ram_we,
	output logic [AW-1:0]                       ram_waddr,
	output logic [7:0]                          ram_wdata,
	output logic [AW-1:0]                       ram_raddr,
	input  logic [7:0]                          ram_rdata,
	output logic                                done,
	output logic [1:0]                          done_type,
	output logic [7:0]                          read_height,
	output logic [15:0]                         sampled_height
);
	import hbs_pkg::*;

	localparam int CW         = $clog2(GRID_SIDE);
	localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int POS_W      = CW + 20;

	state_t state_q, state_d;

	req_t                     type_q;
	logic [13:0]              idx_q;
	logic [7:0]               hgt_q;
	logic signed [15:0]       wx_q, wz_q;
	logic [15:0]              rad_q;
	logic                     raise_q;
	logic [CW-1:0]            x0_q, x1_q, z0_q, z1_q;
	logic [7:0]               fx_q, fz_q;
	logic [7:0]               h00_q, h10_q, h01_q, h11_q;
	logic signed [17:0]       h0_q, h1_q;
	logic [35:0]              r2_q, dz2_q;
	logic signed [POS_W-1:0]  posz_q, posx_q;
	logic [CW-1:0]            xc_q, zc_q;
	logic                     row_far_q, dx_far_q;
	logic                     done_q;
	logic [1:0]               done_type_q;
	logic [7:0]               read_height_q;
	logic [15:0]              sampled_height_q;

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] z, input logic [CW-1:0] x);
		int a;
		a = int'(z) * GRID_SIDE + int'(x);
		return a[AW-1:0];
	endfunction

	// Grid location from the scaled product: floor cell, clamped corners, fraction
	logic signed [17:0] cell_s;
	logic               cell_lo, cell_hi;
	logic [CW-1:0]      c0, c1;
	logic [7:0]         frac;

	always_comb begin
		cell_s  = mul_p[FRAC_BITS+17:FRAC_BITS];
		cell_lo = cell_s < 0;
		cell_hi = cell_s >= $signed(18'(GRID_SIDE - 1));
		if (cell_lo) begin
			c0   = '0;
			c1   = '0;
			frac = '0;
		end else if (cell_hi) begin
			c0   = CW'(GRID_SIDE - 1);
			c1   = CW'(GRID_SIDE - 1);
			frac = '0;
		end else begin
			c0   = cell_s[CW-1:0];
			c1   = cell_s[CW-1:0] + 1'b1;
			frac = mul_p[FRAC_BITS-1:FRAC_BITS-8];
		end
	end

	// Brush geometry in Q.8 metres
	logic signed [POS_W-1:0] half_p, base_x, base_z, r_p, dz_abs, dx_abs;
	logic                    far_z, far_x, in_radius;
	logic [36:0]             dist2;
	logic [7:0]              brushed;

	always_comb begin
		half_p  = POS_W'({cfg.half_size, 8'b0});
		r_p     = POS_W'({rad_q, 2'b0});
		base_x  = -half_p - (POS_W'(wx_q) <<< 2);
		base_z  = -half_p - (POS_W'(wz_q) <<< 2);
		dz_abs  = (posz_q < 0) ? -posz_q : posz_q;
		dx_abs  = (posx_q < 0) ? -posx_q : posx_q;
		far_z   = dz_abs > r_p;
		far_x   = dx_abs > r_p;
		dist2   = {1'b0, dz2_q} + {1'b0, mul_p[35:0]};
		in_radius = !row_far_q && !dx_far_q && (dist2 <= {1'b0, r2_q});
		brushed = ram_rdata;
		if (raise_q) begin
			if (ram_rdata != 8'hFF) brushed = ram_rdata + 8'd1;
		end else begin
			if (ram_rdata != 8'h00) brushed = ram_rdata - 8'd1;
		end
	end

	// Interpolation sums
	logic signed [17:0] h0_n, h1_n;
	logic signed [25:0] h_fin;
	logic [25:0]        h_shr;
	logic               idx_ok;

	always_comb begin
		h0_n   = $signed({2'b0, h00_q, 8'b0}) + $signed(mul_p[17:0]);
		h1_n   = $signed({2'b0, h01_q, 8'b0}) + $signed(mul_p[17:0]);
		h_fin  = $signed({h0_q, 8'b0}) + $signed(mul_p[25:0]);
		h_shr  = h_fin[25] ? '0 : (26'(h_fin) >> (5'd8 + 5'(cfg.height_shift)));
		idx_ok = int'(idx_q) < CELL_COUNT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		ram_we    = 1'b0;
		ram_waddr = addr_of(zc_q, xc_q);
		ram_wdata = brushed;
		ram_raddr = addr_of(zc_q, xc_q);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (req_t'(req_type))
						REQ_WRITE:  state_d = ST_WR;
						REQ_READ:   state_d = ST_RD_A;
						REQ_SAMPLE: state_d = ST_SX;
						REQ_BRUSH:  state_d = ST_B_INIT;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_WR: begin
				ram_we    = idx_ok;
				ram_waddr = AW'(32'(idx_q));
				ram_wdata = hgt_q;
				state_d   = ST_IDLE;
			end
			ST_RD_A: begin
				ram_raddr = AW'(32'(idx_q));
				state_d   = ST_RD_D;
			end
			ST_RD_D: state_d = ST_IDLE;
			ST_SX: begin
				mul_a   = MUL_W'(wx_q) + MUL_W'({cfg.half_size, 6'b0});
				mul_b   = MUL_W'(cfg.step_recip);
				state_d = ST_SZ;
			end
			ST_SZ: begin
				mul_a   = MUL_W'(wz_q) + MUL_W'({cfg.half_size, 6'b0});
				mul_b   = MUL_W'(cfg.step_recip);
				state_d = ST_SLZ;
			end
			ST_SLZ: state_d = ST_SR0;
			ST_SR0: begin
				ram_raddr = addr_of(z0_q, x0_q);
				state_d   = ST_SR1;
			end
			ST_SR1: begin
				ram_raddr = addr_of(z0_q, x1_q);
				state_d   = ST_SR2;
			end
			ST_SR2: begin
				ram_raddr = addr_of(z1_q, x0_q);
				state_d   = ST_SR3;
			end
			ST_SR3: begin
				ram_raddr = addr_of(z1_q, x1_q);
				state_d   = ST_SM0;
			end
			ST_SM0: begin
				mul_a   = MUL_W'(fx_q);
				mul_b   = MUL_W'($signed({1'b0, h10_q}) - $signed({1'b0, h00_q}));
				state_d = ST_SM1;
			end
			ST_SM1: begin
				mul_a   = MUL_W'(fx_q);
				mul_b   = MUL_W'($signed({1'b0, h11_q}) - $signed({1'b0, h01_q}));
				state_d = ST_SM2;
			end
			ST_SM2: state_d = ST_SM3;
			ST_SM3: begin
				mul_a   = MUL_W'(fz_q);
				mul_b   = MUL_W'(h1_q - h0_q);
				state_d = ST_SFIN;
			end
			ST_SFIN: state_d = ST_IDLE;
			ST_B_INIT: begin
				mul_a   = MUL_W'({rad_q, 2'b0});
				mul_b   = MUL_W'({rad_q, 2'b0});
				state_d = ST_B_R2;
			end
			ST_B_R2: state_d = ST_B_ROW;
			ST_B_ROW: begin
				mul_a   = far_z ? '0 : MUL_W'(dz_abs);
				mul_b   = far_z ? '0 : MUL_W'(dz_abs);
				state_d = ST_B_DZ;
			end
			ST_B_DZ: state_d = ST_B_CA;
			ST_B_CA: begin
				mul_a   = far_x ? '0 : MUL_W'(dx_abs);
				mul_b   = far_x ? '0 : MUL_W'(dx_abs);
				state_d = ST_B_CB;
			end
			ST_B_CB: begin
				ram_we = in_radius;
				if (xc_q != CW'(GRID_SIDE - 1)) begin
					state_d = ST_B_CA;
				end else if (zc_q != CW'(GRID_SIDE - 1)) begin
					state_d = ST_B_ROW;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Payload and sample/brush working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				type_q  <= req_t'(req_type);
				idx_q   <= cell_index;
				hgt_q   <= cell_height;
				wx_q    <= world_x;
				wz_q    <= world_z;
				rad_q   <= brush_radius;
				raise_q <= raise_not_lower;
			end
			ST_SZ: begin
				x0_q <= c0;
				x1_q <= c1;
				fx_q <= frac;
			end
			ST_SLZ: begin
				z0_q <= c0;
				z1_q <= c1;
				fz_q <= frac;
			end
			ST_SR1: h00_q <= ram_rdata;
			ST_SR2: h10_q <= ram_rdata;
			ST_SR3: h01_q <= ram_rdata;
			ST_SM0: h11_q <= ram_rdata;
			ST_SM1: h0_q  <= h0_n;
			ST_SM2: h1_q  <= h1_n;
			ST_B_INIT: begin
				posz_q <= base_z;
				zc_q   <= '0;
			end
			ST_B_R2: r2_q <= mul_p[35:0];
			ST_B_ROW: begin
				row_far_q <= far_z;
				xc_q      <= '0;
				posx_q    <= base_x;
			end
			ST_B_DZ: dz2_q <= mul_p[35:0];
			ST_B_CA: dx_far_q <= far_x;
			ST_B_CB: begin
				if (xc_q != CW'(GRID_SIDE - 1)) begin
					xc_q   <= xc_q + 1'b1;
					posx_q <= posx_q + POS_W'(cfg.grid_step);
				end else begin
					zc_q   <= zc_q + 1'b1;
					posz_q <= posz_q + POS_W'(cfg.grid_step);
				end
			end
			default: ;
		endcase
	end

	// Result register: one strobe per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q           <= 1'b0;
			done_type_q      <= '0;
			read_height_q    <= '0;
			sampled_height_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (state_q != ST_IDLE && state_d == ST_IDLE) begin
				done_q           <= 1'b1;
				done_type_q      <= type_q;
				read_height_q    <= (state_q == ST_RD_D && idx_ok) ? ram_rdata : 8'd0;
				sampled_height_q <= (state_q == ST_SFIN) ? h_shr[15:0] : 16'd0;
			end
		end
	end

	assign busy           = state_q != ST_IDLE;
	assign done           = done_q;
	assign done_type      = done_type_q;
	assign read_height    = read_height_q;
	assign sampled_height = sampled_height_q;

endmodule

// ===== hdl/heightmap_bilinear_sampler_brush.sv =====
// Top level of the heightmap sampler and brush.
// Takes one request while busy is low and start is high, then keeps busy high until the
// single result strobe on done, which lasts one cycle and cannot be held off. The
// sequencer steps one shared multiplier and one height store port through every request;
// the brush visits every cell with one read and one conditional write. The store is not
// cleared: cells must be written before they are read or sampled.
// Configuration may be written at any time the block is idle.
module heightmap_bilinear_sampler_brush #(
	parameter int GRID_SIDE = hbs_pkg::GRID_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic [13:0]        cell_index,
	input  logic [7:0]         cell_height,
	input  logic signed [15:0] world_x,
	input  logic signed [15:0] world_z,
	input  logic [15:0]        brush_radius,
	input  logic               raise_not_lower,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_wdata,
	output logic               done,
	output logic [1:0]         done_type,
	output logic [7:0]         read_height,
	output logic [15:0]        sampled_height
);
	import hbs_pkg::*;

	localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int AW         = $clog2(CELL_COUNT);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_size    <= HALF_SIZE_RST;
			cfg_q.grid_step    <= GRID_STEP_RST;
			cfg_q.step_recip   <= STEP_RECIP_RST;
			cfg_q.height_shift <= HEIGHT_SHIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_HALF_SIZE:    cfg_q.half_size    <= cfg_wdata[9:0];
				CFG_GRID_STEP:    cfg_q.grid_step    <= cfg_wdata;
				CFG_STEP_RECIP:   cfg_q.step_recip   <= cfg_wdata;
				CFG_HEIGHT_SHIFT: cfg_q.height_shift <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic [7:0]               ram_wdata, ram_rdata;

	hbs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	hbs_ram #(
		.DEPTH (CELL_COUNT),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	hbs_ctrl #(
		.GRID_SIDE (GRID_SIDE),
		.AW        (AW)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.cell_index      (cell_index),
		.cell_height     (cell_height),
		.world_x         (world_x),
		.world_z         (world_z),
		.brush_radius    (brush_radius),
		.raise_not_lower (raise_not_lower),
		.mul_a           (mul_a),
		.mul_b           (mul_b),
		.mul_p           (mul_p),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.done            (done),
		.done_type       (done_type),
		.read_height     (read_height),
		.sampled_height  (sampled_height)
	);

endmodule

// ===== hdl/hbs_chk.sv =====
// Port-level checks of the heightmap sampler, bound to the top level.
module hbs_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  done_type,
	input logic [7:0]  read_height,
	input logic [15:0] sampled_height
);
	import hbs_pkg::*;

	// An accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// A result appears only as the block drops busy
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe outside the end of an item");

	// Busy drops only with a result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("item finished without a result");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && done_type != REQ_READ |-> read_height == 8'd0)
		else $error("read height set on a non-read result");

	a_samp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (done_type == REQ_WRITE || done_type == REQ_READ) |-> sampled_height == 16'd0)
		else $error("sampled height set on a cell access result");

endmodule

bind heightmap_bilinear_sampler_brush hbs_chk u_hbs_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.done_type      (done_type),
	.read_height    (read_height),
	.sampled_height (sampled_height)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the heightmap sampler and brush.
`timescale 1ns / 100ps

module tb;
	import hbs_pkg::*;

	localparam int SIDE      = GRID_SIDE_DEF;
	localparam int CELLS     = SIDE * SIDE;
	localparam int RAND_ITEMS = 1750;
	localparam longint LIMIT = 4000000;

	typedef struct {
		req_t        kind;
		logic [13:0] idx;
		logic [7:0]  hgt;
		logic [15:0] wx;
		logic [15:0] wz;
		logic [15:0] radius;
		logic        raise;
		bit          typed;
		logic [7:0]  rd_exp;
		logic [15:0] smp_exp;
	} row_t;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  rd;
		logic [15:0] smp;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] req_type = '0;
	logic [13:0] cell_index = '0;
	logic [7:0] cell_height = '0;
	logic signed [15:0] world_x = '0;
	logic signed [15:0] world_z = '0;
	logic [15:0] brush_radius = '0;
	logic raise_not_lower = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic done;
	logic [1:0] done_type;
	logic [7:0] read_height;
	logic [15:0] sampled_height;

	cfg_t cfg;
	logic [7:0] heights [CELLS];
	result_t pending [$];
	int errors = 0;
	longint cycles = 0;
	int idle_pct = 0;

	heightmap_bilinear_sampler_brush i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .cell_index(cell_index), .cell_height(cell_height),
		.world_x(world_x), .world_z(world_z), .brush_radius(brush_radius),
		.raise_not_lower(raise_not_lower), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .done(done), .done_type(done_type),
		.read_height(read_height), .sampled_height(sampled_height)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("** heightmap_bilinear_sampler_brush: FAILED **");
			$finish;
		end
	end

	// Grid cell and Q0.8 fraction of one world coordinate, clamped to the grid
	function automatic void locate(input logic [15:0] w, output int c0, output int c1,
			output int frac);
		longint p, g, cell_n;
		p = longint'($signed(w)) + longint'(cfg.half_size) * 64;
		g = p * longint'(cfg.step_recip);
		cell_n = g >>> FRAC_BITS;
		if (cell_n < 0) begin
			c0 = 0; c1 = 0; frac = 0;
		end else if (cell_n >= SIDE - 1) begin
			c0 = SIDE - 1; c1 = SIDE - 1; frac = 0;
		end else begin
			c0 = int'(cell_n); c1 = int'(cell_n) + 1;
			frac = int'(((g - (cell_n <<< FRAC_BITS)) >> (FRAC_BITS - 8)) & 255);
		end
	endfunction

	function automatic logic [15:0] bilinear_height(logic [15:0] wx, logic [15:0] wz);
		int x0, x1, z0, z1, fx, fz;
		longint h00, h10, h01, h11, h0, h1, h;
		locate(wx, x0, x1, fx);
		locate(wz, z0, z1, fz);
		h00 = heights[z0 * SIDE + x0];
		h10 = heights[z0 * SIDE + x1];
		h01 = heights[z1 * SIDE + x0];
		h11 = heights[z1 * SIDE + x1];
		h0 = h00 * 256 + fx * (h10 - h00);
		h1 = h01 * 256 + fx * (h11 - h01);
		h = h0 * 256 + fz * (h1 - h0);
		if (h < 0) h = 0;
		return 16'(h >> (8 + cfg.height_shift));
	endfunction

	function automatic void apply_brush(logic [15:0] wx, logic [15:0] wz,
			logic [15:0] radius, logic raise);
		longint cx, cz, half, r2, dx, dz;
		cx = longint'($signed(wx)) * 4;
		cz = longint'($signed(wz)) * 4;
		half = longint'(cfg.half_size) * 256;
		r2 = longint'(radius) * 4 * longint'(radius) * 4;
		for (int z = 0; z < SIDE; z++) begin
			dz = longint'(z) * cfg.grid_step - half - cz;
			for (int x = 0; x < SIDE; x++) begin
				dx = longint'(x) * cfg.grid_step - half - cx;
				if (dx * dx + dz * dz <= r2) begin
					if (raise && heights[z * SIDE + x] != 8'd255)
						heights[z * SIDE + x]++;
					else if (!raise && heights[z * SIDE + x] != 8'd0)
						heights[z * SIDE + x]--;
				end
			end
		end
	endfunction

	function automatic result_t predict_request(row_t r);
		result_t res;
		res = '{kind: r.kind, rd: '0, smp: '0};
		case (r.kind)
			REQ_WRITE: heights[r.idx] = r.hgt;
			REQ_READ: res.rd = heights[r.idx];
			REQ_SAMPLE: res.smp = bilinear_height(r.wx, r.wz);
			default: apply_brush(r.wx, r.wz, r.radius, r.raise);
		endcase
		return res;
	endfunction

	// Drive one item, hold until taken, then maybe go quiet for a while
	task automatic send(row_t r);
		result_t res;
		start <= 1'b1;
		req_type <= r.kind;
		cell_index <= r.idx;
		cell_height <= r.hgt;
		world_x <= r.wx;
		world_z <= r.wz;
		brush_radius <= r.radius;
		raise_not_lower <= r.raise;
		do @(posedge clk); while (busy);
		res = predict_request(r);
		if (r.typed) begin
			res.rd = r.rd_exp;
			res.smp = r.smp_exp;
		end
		pending.push_back(res);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Hold the write enable high; the caller drops it after the last register
	task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic configure(cfg_t c);
		drain();
		cfg = c;
		write_reg(CFG_HALF_SIZE, 16'(c.half_size));
		write_reg(CFG_GRID_STEP, c.grid_step);
		write_reg(CFG_STEP_RECIP, c.step_recip);
		write_reg(CFG_HEIGHT_SHIFT, 16'(c.height_shift));
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_coord();
		int span;
		span = int'(cfg.half_size) * 64;
		if ($urandom_range(0, 1)) return 16'($urandom);
		return 16'(int'($urandom_range(0, 2 * span + 128)) - span - 64);
	endfunction

	function automatic row_t random_row();
		row_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.kind = pick < 30 ? REQ_WRITE : pick < 55 ? REQ_READ : pick < 99 ? REQ_SAMPLE
			: REQ_BRUSH;
		r.idx = 14'($urandom);
		r.hgt = 8'($urandom);
		r.wx = pick_coord();
		r.wz = pick_coord();
		r.radius = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2000));
		r.raise = 1'($urandom);
		r.typed = 1'b0;
		r.rd_exp = '0;
		r.smp_exp = '0;
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				$error("result with nothing expected: done_type %0d", done_type);
				errors++;
			end else begin
				want = pending.pop_front();
				if (done_type !== want.kind) begin
					$error("done_type expected %0d got %0d", want.kind, done_type);
					errors++;
				end
				if (read_height !== want.rd) begin
					$error("read_height expected %0d got %0d", want.rd, read_height);
					errors++;
				end
				if (sampled_height !== want.smp) begin
					$error("sampled_height expected %0d got %0d", want.smp, sampled_height);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t rows [$];
		row_t r;
		cfg_t settings [6];
		cfg = '{HALF_SIZE_RST, GRID_STEP_RST, STEP_RECIP_RST, HEIGHT_SHIFT_RST};
		settings[0] = cfg;
		settings[1] = '{10'd0, 16'd1, 16'd1, 3'd0};
		settings[2] = '{10'd1023, 16'd65535, 16'd65535, 3'd7};
		settings[3] = '{10'd64, 16'd256, 16'd65535, 3'd0};
		settings[4] = '{10'd32, 16'd128, 16'd32768, 3'd3};
		settings[5] = '{10'($urandom), 16'($urandom_range(1, 65535)),
			16'($urandom_range(1, 65535)), 3'($urandom)};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fill every cell first: the store has no reset
		r = '{REQ_WRITE, '0, '0, '0, '0, '0, 1'b0, 1'b0, '0, '0};
		for (int i = 0; i < CELLS; i++) begin
			r.idx = 14'(i);
			r.hgt = 8'($urandom);
			send(r);
		end

		configure(settings[0]);
		rows.push_back('{REQ_WRITE, 14'd0, 8'd200, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 8'd0, 16'd0});
		rows.push_back('{REQ_WRITE, 14'd16383, 8'd255, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 8'd0,
			16'd0});
		rows.push_back('{REQ_READ, 14'd0, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 8'd200, 16'd0});
		rows.push_back('{REQ_READ, 14'd16383, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 8'd255,
			16'd0});
		// far below the grid clamps to cell 0,0; far above to the last cell
		rows.push_back('{REQ_SAMPLE, 14'd0, 8'd0, 16'h8000, 16'h8000, 16'd0, 1'b0, 1'b1, 8'd0,
			16'd12800});
		rows.push_back('{REQ_SAMPLE, 14'd0, 8'd0, 16'h7FFF, 16'h7FFF, 16'd0, 1'b0, 1'b1, 8'd0,
			16'd16320});
		rows.push_back('{REQ_SAMPLE, 14'd0, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0});
		rows.push_back('{REQ_SAMPLE, 14'd0, 8'd0, 16'd100, 16'hFF38, 16'd0, 1'b0, 1'b0, 8'd0,
			16'd0});
		rows.push_back('{REQ_WRITE, 14'd5, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0});
		rows.push_back('{REQ_WRITE, 14'd6, 8'd255, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0});
		rows.push_back('{REQ_BRUSH, 14'd0, 8'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1, 1'b0, 8'd0, 16'd0});
		rows.push_back('{REQ_READ, 14'd6, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0});
		// zero radius centred on cell 0 touches that cell alone
		rows.push_back('{REQ_BRUSH, 14'd0, 8'd0, 16'hC000, 16'hC000, 16'd0, 1'b0, 1'b0, 8'd0,
			16'd0});
		rows.push_back('{REQ_READ, 14'd0, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0});
		rows.push_back('{REQ_READ, 14'd1, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0});
		rows.push_back('{REQ_READ, 14'd5, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 8'd0, 16'd0});
		foreach (rows[i]) send(rows[i]);

		for (int ph = 0; ph < 6; ph++) begin
			configure(settings[ph]);
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 87;
				default: idle_pct = 16;
			endcase
			for (int n = 0; n < RAND_ITEMS / 6; n++) send(random_row());
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("** heightmap_bilinear_sampler_brush: PASSED **");
		else
			$display("** heightmap_bilinear_sampler_brush: FAILED **");
		$finish;
	end

endmodule
